// File: rtl/core/sorted_key_table_top_assert.svh
// Assertion macros for the sorted key table.
// Each macro checks on the rising edge of i_clk and is idle while i_rst_n is low.
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SKT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");
`define SKT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");
`else
`define SKT_ASSERT_IMP(lbl, ante, cons)
`define SKT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/skt_pkg.sv
package skt_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_BSEARCH,
        OP_LSEARCH,
        OP_CLEAR,
        OP_SORT
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

// File: rtl/core/skt_ram.sv
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sorted_key_table_top.sv
// Operations: read fetches one entry, add/insert moves each entry at or above the slot up,
// delete moves each entry above the removed one down, binary search halves the range and then
// steps back over equal neighbours, linear search visits entries in order, sort is a heap sort.
// Throughput: one word at a time; the single read port of the key store sets the pace.
// Reset: synchronous, active low; returns to idle and clears the entry count, the mode and the output valid flag.
// Key store contents are undefined after reset and need no clearing pass.
`include "sorted_key_table_top_assert.svh"

module sorted_key_table_top #(
    parameter int CAPACITY  = skt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_key,
    input  logic [8:0]  i_position,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [8:0]  o_result_index,
    output logic [31:0] o_result_key,
    output logic [8:0]  o_entry_count
);

    import skt_pkg::*;

    // CW addresses the store, NW holds a count up to CAPACITY, HW holds a heap child.
    localparam int CW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int HW = NW + 1;
    localparam int PW = (NW > 9) ? NW : 9;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_ISSUE, S_RD_WAIT,
        S_BS_RD, S_BS_CMP, S_BS_BK_RD, S_BS_BK_CMP, S_BS_FIN,
        S_INS_RD, S_INS_WR,
        S_DEL_RD, S_DEL_WR,
        S_LS_RD, S_LS_CMP,
        S_HS_BUILD, S_HS_EXT, S_HS_EXT0, S_HS_EXTI,
        S_SF_HRD, S_SF_HWAIT, S_SF_LOOP, S_SF_C0, S_SF_C1, S_SF_DEC,
        S_DONE
    } t_state;

    t_state               r_state;
    t_op                  r_op;
    logic                 r_mode;
    logic [NW-1:0]        r_cnt;
    logic [KEY_WIDTH-1:0] r_key;
    // working result
    t_status              r_status;
    logic                 r_found;
    logic [NW-1:0]        r_idx;
    logic [31:0]          r_rkey;
    // walk pointers
    logic [NW-1:0]        r_j;
    logic [NW-1:0]        r_lo;
    logic [NW-1:0]        r_hix;
    logic [NW-1:0]        r_mid;
    logic                 r_last_gt;
    // heap sort
    logic                 r_phase;
    logic [NW-1:0]        r_i;
    logic [NW-1:0]        r_top;
    logic [NW-1:0]        r_last;
    logic [NW-1:0]        r_first;
    logic [HW-1:0]        r_child;
    logic [NW-1:0]        r_csel;
    logic [KEY_WIDTH-1:0] r_cval;
    logic [KEY_WIDTH-1:0] r_held;
    logic [KEY_WIDTH-1:0] r_tmp;
    // output word
    logic                 r_ovalid;
    t_status              r_o_status;
    logic                 r_o_found;
    logic [NW-1:0]        r_o_idx;
    logic [31:0]          r_o_rkey;
    logic [NW-1:0]        r_o_cnt;

    logic                 w_acc;
    t_op                  w_op;
    logic [PW-1:0]        w_pos;
    logic [PW-1:0]        w_cntp;
    logic [NW:0]          w_sum;
    logic [NW-1:0]        w_mid;
    logic [NW:0]          w_j1;
    logic                 w_full;
    logic [KEY_WIDTH-1:0] w_rd;
    logic                 w_re;
    logic [CW-1:0]        w_raddr;
    logic                 w_we;
    logic [CW-1:0]        w_waddr;
    logic [KEY_WIDTH-1:0] w_wdata;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_op       = t_op'(i_op);
    assign w_pos      = PW'(i_position);
    assign w_cntp     = PW'(r_cnt);
    assign w_full     = (r_cnt == NW'(CAPACITY));
    // midpoint of [lo, hix-1]; only used while lo < hix, so no underflow
    assign w_sum      = (NW+1)'(r_lo) + (NW+1)'(r_hix) - (NW+1)'(1);
    assign w_mid      = NW'(w_sum >> 1);
    assign w_j1       = (NW+1)'(r_j) + (NW+1)'(1);

    skt_ram #(
        .WIDTH(KEY_WIDTH),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    // Store port control: every read is registered and lands in the state that follows.
    always_comb begin
        w_re    = 1'b0;
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_held;
        case (r_state)
            S_RD_ISSUE: begin
                w_re    = 1'b1;
                w_raddr = CW'(r_j);
            end
            S_BS_RD: begin
                w_re    = (r_lo < r_hix);
                w_raddr = CW'(w_mid);
            end
            S_BS_BK_RD: begin
                w_re    = (r_mid != '0);
                w_raddr = CW'(r_mid - NW'(1));
            end
            S_INS_RD: begin
                // move the entry below up, or drop the new key into the gap
                if (r_j > r_idx) begin
                    w_re    = 1'b1;
                    w_raddr = CW'(r_j - NW'(1));
                end else begin
                    w_we    = 1'b1;
                    w_waddr = CW'(r_idx);
                    w_wdata = r_key;
                end
            end
            S_INS_WR, S_DEL_WR: begin
                w_we    = 1'b1;
                w_waddr = CW'(r_j);
                w_wdata = w_rd;
            end
            S_DEL_RD: begin
                w_re    = (w_j1 < (NW+1)'(r_cnt));
                w_raddr = CW'(w_j1);
            end
            S_LS_RD: begin
                w_re    = (r_j < r_cnt);
                w_raddr = CW'(r_j);
            end
            S_HS_EXT: begin
                w_re    = (r_i != '0);
                w_raddr = '0;
            end
            S_HS_EXT0: begin
                w_re    = 1'b1;
                w_raddr = CW'(r_i);
            end
            S_HS_EXTI: begin
                // old root goes to the tail; the tail key sifts down from the root
                w_we    = 1'b1;
                w_waddr = CW'(r_i);
                w_wdata = r_tmp;
            end
            S_SF_HRD: begin
                w_re    = 1'b1;
                w_raddr = CW'(r_first);
            end
            S_SF_LOOP: begin
                if (r_child <= HW'(r_last)) begin
                    w_re    = 1'b1;
                    w_raddr = CW'(r_child);
                end else begin
                    w_we    = 1'b1;
                    w_waddr = CW'(r_first);
                    w_wdata = r_held;
                end
            end
            S_SF_C0: begin
                w_re    = (r_child < HW'(r_last));
                w_raddr = CW'(r_child + HW'(1));
            end
            S_SF_DEC: begin
                w_we    = 1'b1;
                w_waddr = CW'(r_first);
                w_wdata = (r_held < r_cval) ? r_cval : r_held;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_mode   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            // drop the output word once taken, unless a new one is loaded below
            if (r_ovalid && !i_out_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op     <= w_op;
                        r_key    <= KEY_WIDTH'(i_key);
                        r_status <= ST_OK;
                        r_found  <= 1'b0;
                        r_idx    <= '0;
                        r_rkey   <= '0;
                        case (w_op)
                            OP_ADD: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else if (r_mode) begin
                                    r_lo      <= '0;
                                    r_hix     <= r_cnt;
                                    r_mid     <= '0;
                                    r_last_gt <= 1'b0;
                                    r_state   <= S_BS_RD;
                                end else begin
                                    r_idx   <= r_cnt;
                                    r_j     <= r_cnt;
                                    r_state <= S_INS_RD;
                                end
                            end
                            OP_INSERT: begin
                                // index check before full check
                                if (w_pos > w_cntp) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else if (w_full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_idx   <= NW'(w_pos);
                                    r_j     <= r_cnt;
                                    r_state <= S_INS_RD;
                                end
                            end
                            OP_DELETE: begin
                                if (w_pos >= w_cntp) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_idx   <= NW'(w_pos);
                                    r_j     <= NW'(w_pos);
                                    r_state <= S_DEL_RD;
                                end
                            end
                            OP_READ: begin
                                if (w_pos >= w_cntp) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_idx   <= NW'(w_pos);
                                    r_j     <= NW'(w_pos);
                                    r_state <= S_RD_ISSUE;
                                end
                            end
                            OP_BSEARCH: begin
                                r_lo      <= '0;
                                r_hix     <= r_cnt;
                                r_mid     <= '0;
                                r_last_gt <= 1'b0;
                                r_state   <= S_BS_RD;
                            end
                            OP_LSEARCH: begin
                                r_idx   <= r_cnt;
                                r_j     <= '0;
                                r_state <= S_LS_RD;
                            end
                            OP_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                // sort: fewer than two entries is a no-op
                                if (r_cnt < NW'(2)) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_top   <= r_cnt - NW'(1);
                                    r_i     <= ((r_cnt - NW'(1)) >> 1) + NW'(1);
                                    r_phase <= 1'b0;
                                    r_state <= S_HS_BUILD;
                                end
                            end
                        endcase
                    end
                end
                S_RD_ISSUE: begin
                    r_state <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    r_rkey  <= 32'(w_rd);
                    r_state <= S_DONE;
                end
                S_BS_RD: begin
                    if (r_lo < r_hix) begin
                        r_mid   <= w_mid;
                        r_state <= S_BS_CMP;
                    end else begin
                        // a miss answers low after a larger compare, else middle
                        r_idx   <= r_last_gt ? r_lo : r_mid;
                        r_state <= S_BS_FIN;
                    end
                end
                S_BS_CMP: begin
                    if (r_key < w_rd) begin
                        r_hix     <= r_mid;
                        r_last_gt <= 1'b0;
                        r_state   <= S_BS_RD;
                    end else if (r_key > w_rd) begin
                        r_lo      <= r_mid + NW'(1);
                        r_last_gt <= 1'b1;
                        r_state   <= S_BS_RD;
                    end else begin
                        r_found <= 1'b1;
                        r_state <= S_BS_BK_RD;
                    end
                end
                S_BS_BK_RD: begin
                    // step back over equal neighbours
                    if (r_mid != '0) begin
                        r_state <= S_BS_BK_CMP;
                    end else begin
                        r_idx   <= r_mid;
                        r_state <= S_BS_FIN;
                    end
                end
                S_BS_BK_CMP: begin
                    if (w_rd == r_key) begin
                        r_mid   <= r_mid - NW'(1);
                        r_state <= S_BS_BK_RD;
                    end else begin
                        r_idx   <= r_mid;
                        r_state <= S_BS_FIN;
                    end
                end
                S_BS_FIN: begin
                    if (r_op == OP_ADD) begin
                        r_found <= 1'b0;
                        r_j     <= r_cnt;
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_INS_RD: begin
                    if (r_j > r_idx) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_cnt   <= r_cnt + NW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_INS_WR: begin
                    r_j     <= r_j - NW'(1);
                    r_state <= S_INS_RD;
                end
                S_DEL_RD: begin
                    if (w_j1 < (NW+1)'(r_cnt)) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_cnt   <= r_cnt - NW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DEL_WR: begin
                    r_j     <= r_j + NW'(1);
                    r_state <= S_DEL_RD;
                end
                S_LS_RD: begin
                    r_state <= (r_j < r_cnt) ? S_LS_CMP : S_DONE;
                end
                S_LS_CMP: begin
                    if (w_rd == r_key) begin
                        r_found <= 1'b1;
                        r_idx   <= r_j;
                        r_state <= S_DONE;
                    end else begin
                        r_j     <= r_j + NW'(1);
                        r_state <= S_LS_RD;
                    end
                end
                S_HS_BUILD: begin
                    if (r_i != '0) begin
                        r_first <= r_i - NW'(1);
                        r_last  <= r_top;
                        r_i     <= r_i - NW'(1);
                        r_state <= S_SF_HRD;
                    end else begin
                        r_phase <= 1'b1;
                        r_i     <= r_top;
                        r_state <= S_HS_EXT;
                    end
                end
                S_HS_EXT: begin
                    r_state <= (r_i != '0) ? S_HS_EXT0 : S_DONE;
                end
                S_HS_EXT0: begin
                    r_tmp   <= w_rd;
                    r_state <= S_HS_EXTI;
                end
                S_HS_EXTI: begin
                    r_held  <= w_rd;
                    r_first <= '0;
                    r_last  <= r_i - NW'(1);
                    r_child <= HW'(1);
                    r_i     <= r_i - NW'(1);
                    r_state <= S_SF_LOOP;
                end
                S_SF_HRD: begin
                    r_state <= S_SF_HWAIT;
                end
                S_SF_HWAIT: begin
                    r_held  <= w_rd;
                    r_child <= {r_first, 1'b1};
                    r_state <= S_SF_LOOP;
                end
                S_SF_LOOP: begin
                    if (r_child <= HW'(r_last)) begin
                        r_state <= S_SF_C0;
                    end else begin
                        r_state <= r_phase ? S_HS_EXT : S_HS_BUILD;
                    end
                end
                S_SF_C0: begin
                    r_cval  <= w_rd;
                    r_csel  <= NW'(r_child);
                    r_state <= (r_child < HW'(r_last)) ? S_SF_C1 : S_SF_DEC;
                end
                S_SF_C1: begin
                    // take the larger child
                    if (r_cval < w_rd) begin
                        r_cval <= w_rd;
                        r_csel <= NW'(r_child + HW'(1));
                    end
                    r_state <= S_SF_DEC;
                end
                S_SF_DEC: begin
                    if (r_held < r_cval) begin
                        r_first <= r_csel;
                        r_child <= {r_csel, 1'b1};
                        r_state <= S_SF_LOOP;
                    end else begin
                        r_state <= r_phase ? S_HS_EXT : S_HS_BUILD;
                    end
                end
                S_DONE: begin
                    // hold until the output word is free or leaving this cycle
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_status;
                        r_o_found  <= r_found;
                        r_o_idx    <= r_idx;
                        r_o_rkey   <= r_rkey;
                        r_o_cnt    <= r_cnt;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_o_status;
    assign o_found        = r_o_found;
    assign o_result_index = 9'(r_o_idx);
    assign o_result_key   = r_o_rkey;
    assign o_entry_count  = 9'(r_o_cnt);

    `SKT_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= NW'(CAPACITY))
    `SKT_ASSERT_NXT(a_accept_busy, w_acc, o_in_stall)
    `SKT_ASSERT_IMP(a_wr_range, w_we, {1'b0, w_waddr} < (CW+1)'(CAPACITY))
    `SKT_ASSERT_IMP(a_clear_zero, (r_state == S_DONE) && (r_op == OP_CLEAR), r_cnt == '0)

endmodule
